/* rtl/core/pcm_pkg.sv */
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants for the PWM capture and measure block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

    localparam int RATE_W = 24;
    localparam logic [RATE_W-1:0] RESET_TICK_RATE = 24'd1000000;
    localparam int PCT_SCALE = 100;

    localparam int TICKS_W = 16;
    localparam int DUTY_W  = 7;
    localparam int FREQ_W  = 24;

    // Controller to datapath
    typedef struct packed {
        logic tick;         // advance counter, sample pin
        logic start;        // clear counter
        logic stamp_rise;
        logic stamp_fall;
        logic stamp_end;    // form high, low and period
        logic load_duty;    // divider: high*100 / period
        logic load_freq;    // divider: rate / period
        logic div_step;
        logic save_duty;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rise;
        logic fall;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/pwm_capture_measure_top.sv */
// ----------------------------------------------------------------------------
// pwm_capture_measure_top
// PWM input capture: high/low time, duty in percent and frequency in Hz.
// ----------------------------------------------------------------------------
// Input stream: tuser[0] = kind (0 tick with pin sample, 1 start),
// tdata[0] = pin level. Output stream carries one result per completed
// capture (first rise, fall, second rise after a start); tuser[0] flags a
// zero period, in which case duty and frequency read 0.
// Register 0 at byte address 0 (APB) holds the tick rate in Hz used as the
// frequency numerator; write it only while no capture is in flight.
// Tick and start transactions are taken only while the block is not busy;
// the tick that completes a capture makes it busy while one restoring divider
// forms the duty and then the frequency one quotient bit a cycle over an NW-bit
// numerator, NW = max(width+7, 24), and until the result is loaded for output.
// Results sit in an output register: the input side keeps taking ticks
// while a result waits, and a new result only waits for it to drain
// when the receiver stalls. Reset clears counter, phase and output valid,
// sets the previous pin level high and the tick rate to 1000000.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_capture_measure_top
    import pcm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [0] pin_level, [7:1] zero
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] kind
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [15:0] high_ticks, [31:16] low_ticks,
                                               // [38:32] duty_percent,
                                               // [62:39] frequency_hz, [63] zero
    output logic [0:0]       o_m_axis_tuser,   // [0] period_zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cmd              w_cmd;
    t_status           w_sts;
    logic              w_rate_we;
    logic [RATE_W-1:0] w_rate;
    logic [TICKS_W-1:0] w_high;
    logic [TICKS_W-1:0] w_low;
    logic [DUTY_W-1:0] w_duty;
    logic [FREQ_W-1:0] w_freq;
    logic              w_zero;

    assign pready    = 1'b1;
    assign w_rate_we = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {8'd0, w_rate};

    pcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser[0]),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pcm_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_pin_level    (i_s_axis_tdata[0]),
        .i_rate_we      (w_rate_we),
        .i_rate_wdata   (pwdata[RATE_W-1:0]),
        .o_rate         (w_rate),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_high_ticks   (w_high),
        .o_low_ticks    (w_low),
        .o_duty_percent (w_duty),
        .o_frequency_hz (w_freq),
        .o_period_zero  (w_zero)
    );

    assign o_m_axis_tdata = {1'b0, w_freq, w_duty, w_low, w_high};
    assign o_m_axis_tuser = w_zero;

endmodule

`default_nettype wire

/* rtl/core/pcm_ctrl.sv */
// ----------------------------------------------------------------------------
// pcm_ctrl
// Capture sequencer: tracks the edge phase and runs the two divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ctrl
    import pcm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_kind,
    output logic         o_in_ready,
    input  wire t_status i_sts,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_RUN     = 3'd0;
    localparam logic [2:0] S_DUTY_LD = 3'd1;
    localparam logic [2:0] S_DUTY    = 3'd2;
    localparam logic [2:0] S_FREQ    = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RISE1 = 2'd1;
    localparam logic [1:0] PH_FALL  = 2'd2;
    localparam logic [1:0] PH_RISE2 = 2'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready = (r_state == S_RUN);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_RUN: begin
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_RISE1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (r_phase == PH_RISE1 && i_sts.rise) begin
                            o_cmd.stamp_rise = 1'b1;
                            n_phase          = PH_FALL;
                        end else if (r_phase == PH_FALL && i_sts.fall) begin
                            o_cmd.stamp_fall = 1'b1;
                            n_phase          = PH_RISE2;
                        end else if (r_phase == PH_RISE2 && i_sts.rise) begin
                            o_cmd.stamp_end = 1'b1;
                            n_phase         = PH_IDLE;
                            n_state         = S_DUTY_LD;
                        end
                    end
                end
            end
            S_DUTY_LD: begin
                o_cmd.load_duty = 1'b1;
                n_state         = S_DUTY;
            end
            S_DUTY: begin
                if (i_sts.div_done) begin
                    o_cmd.save_duty = 1'b1;
                    o_cmd.load_freq = 1'b1;
                    n_state         = S_FREQ;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FREQ: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/pcm_datapath.sv */
// ----------------------------------------------------------------------------
// pcm_datapath
// Tick counter, edge timestamps, shared restoring divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_datapath
    import pcm_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_sts,
    input  wire logic              i_pin_level,
    input  wire logic              i_rate_we,
    input  wire logic [RATE_W-1:0] i_rate_wdata,
    output logic [RATE_W-1:0]      o_rate,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [TICKS_W-1:0]     o_high_ticks,
    output logic [TICKS_W-1:0]     o_low_ticks,
    output logic [DUTY_W-1:0]      o_duty_percent,
    output logic [FREQ_W-1:0]      o_frequency_hz,
    output logic                   o_period_zero
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int PW    = CW + 1;                           // period width
    localparam int NW    = (CW + 7 > RATE_W) ? CW + 7 : RATE_W; // numerator width
    localparam int CNT_W = $clog2(NW + 1);

    logic [CW-1:0]     r_tick_counter;
    logic              r_prev_level;
    logic [CW-1:0]     r_rise_time;
    logic [CW-1:0]     r_fall_time;
    logic [CW-1:0]     r_high;
    logic [CW-1:0]     r_low;
    logic [PW-1:0]     r_period;
    logic [RATE_W-1:0] r_rate;
    logic [NW-1:0]     r_num;      // numerator in, quotient out
    logic [PW-1:0]     r_rem;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [DUTY_W-1:0] r_duty;
    logic              r_out_valid;
    logic [TICKS_W-1:0] r_out_high;
    logic [TICKS_W-1:0] r_out_low;
    logic [DUTY_W-1:0] r_out_duty;
    logic [FREQ_W-1:0] r_out_freq;
    logic              r_out_zero;

    logic [CW-1:0]     n_high;
    logic [CW-1:0]     n_low;
    logic [CW+6:0]     w_product;
    logic [PW:0]       w_rem_sh;
    logic [PW:0]       w_rem_sub;
    logic              w_qbit;
    logic              w_zero;
    logic [CW+15:0]    w_high_x;
    logic [CW+15:0]    w_low_x;

    assign n_high    = r_fall_time - r_rise_time;
    assign n_low     = r_tick_counter - r_fall_time;
    assign w_product = {7'b0, r_high} * (CW+7)'(PCT_SCALE);

    // One quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_period});
    assign w_rem_sub = w_rem_sh - {1'b0, r_period};

    assign w_zero    = (r_period == '0);
    assign w_high_x  = {16'b0, r_high};
    assign w_low_x   = {16'b0, r_low};

    assign o_sts.rise     = !r_prev_level && i_pin_level;
    assign o_sts.fall     = r_prev_level && !i_pin_level;
    assign o_sts.div_done = (r_div_cnt == CNT_W'(NW));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_counter <= '0;
            r_prev_level   <= 1'b1;
            r_rate         <= RESET_TICK_RATE;
            r_div_cnt      <= CNT_W'(NW);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_tick_counter <= '0;
            end else if (i_cmd.tick) begin
                r_tick_counter <= r_tick_counter + 1'b1;
                r_prev_level   <= i_pin_level;
            end
            if (i_rate_we) begin
                r_rate <= i_rate_wdata;
            end
            if (i_cmd.load_duty || i_cmd.load_freq) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stamp_rise) begin
            r_rise_time <= r_tick_counter;
        end
        if (i_cmd.stamp_fall) begin
            r_fall_time <= r_tick_counter;
        end
        if (i_cmd.stamp_end) begin
            r_high   <= n_high;
            r_low    <= n_low;
            r_period <= {1'b0, n_high} + {1'b0, n_low};
        end
        if (i_cmd.save_duty) begin
            r_duty <= r_num[DUTY_W-1:0];
        end
        if (i_cmd.load_duty) begin
            r_num <= NW'(w_product);
            r_rem <= '0;
        end else if (i_cmd.load_freq) begin
            r_num <= NW'(r_rate);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NW-2:0], w_qbit};
            r_rem <= w_qbit ? w_rem_sub[PW-1:0] : w_rem_sh[PW-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_high <= w_high_x[TICKS_W-1:0];
            r_out_low  <= w_low_x[TICKS_W-1:0];
            r_out_duty <= w_zero ? '0 : r_duty;
            r_out_freq <= w_zero ? '0 : r_num[FREQ_W-1:0];
            r_out_zero <= w_zero;
        end
    end

    assign o_rate         = r_rate;
    assign o_out_valid    = r_out_valid;
    assign o_high_ticks   = r_out_high;
    assign o_low_ticks    = r_out_low;
    assign o_duty_percent = r_out_duty;
    assign o_frequency_hz = r_out_freq;
    assign o_period_zero  = r_out_zero;

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pwm_capture_measure_top. Tick and start
// transactions are queued by the stimulus process, pushed through the input
// stream with random gaps, and run through a local capture model when
// accepted. Each result on the output stream is checked field by field
// against the oldest predicted measurement. The tick rate register is
// rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcm_pkg::*;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } t_item_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST_RISE,
        PH_FALL,
        PH_SECOND_RISE
    } t_capture_phase;

    typedef struct packed {
        t_item_kind kind;
        logic       pin;
    } t_pin_item;

    typedef struct packed {
        logic [TICKS_W-1:0] high;
        logic [TICKS_W-1:0] low;
        logic [DUTY_W-1:0]  duty;
        logic [FREQ_W-1:0]  freq;
        logic               zero;
    } t_meas;

    localparam logic [2:0] REG_TICK_RATE = 3'd0;
    localparam logic [2:0] REG_SPARE     = 3'd4;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata   = '0;  // [0] pin_level, [7:1] zero
    logic [0:0]  i_s_axis_tuser   = '0;  // [0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready  = 1'b0;
    logic [63:0] o_m_axis_tdata;         // [15:0] high, [31:16] low, [38:32] duty,
                                         // [62:39] frequency, [63] zero
    logic [0:0]  o_m_axis_tuser;         // [0] period_zero
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    pwm_capture_measure_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // capture model state, reset values
    logic [RATE_W-1:0]  tick_rate  = RESET_TICK_RATE;
    logic [TICKS_W-1:0] tick_count = '0;
    logic               prev_level = 1'b1;
    t_capture_phase     phase      = PH_IDLE;
    logic [TICKS_W-1:0] rise_at    = '0;
    logic [TICKS_W-1:0] fall_at    = '0;

    t_pin_item pin_stream_q[$];
    t_meas     meas_expect_q[$];
    int        stim_cnt    = 0;
    int        sent_cnt    = 0;
    int        taken_cnt   = 0;
    int        err_cnt     = 0;
    int        cycle_cnt   = 0;
    bit        no_idle     = 1'b0;
    bit        hold_toggle = 1'b0;
    bit        hold_seen   = 1'b0;
    int        hold_left   = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Advances the model by one transaction; returns 1 when a measurement completes.
    function automatic bit capture_step(input t_pin_item it, output t_meas m);
        logic [TICKS_W-1:0] now;
        logic [31:0]        period;
        bit                 rise;
        bit                 fall;
        bit                 done;
        now  = tick_count;
        done = 1'b0;
        m    = '0;
        if (it.kind == KIND_START) begin
            tick_count = '0;
            phase      = PH_FIRST_RISE;
        end else begin
            rise = !prev_level && it.pin;
            fall = prev_level && !it.pin;
            if (phase == PH_FIRST_RISE && rise) begin
                rise_at = now;
                phase   = PH_FALL;
            end else if (phase == PH_FALL && fall) begin
                fall_at = now;
                phase   = PH_SECOND_RISE;
            end else if (phase == PH_SECOND_RISE && rise) begin
                m.high = fall_at - rise_at;
                m.low  = now - fall_at;
                // sum kept unwrapped so duty stays within 100
                period = 32'(m.high) + 32'(m.low);
                if (period != 0) begin
                    m.duty = DUTY_W'((32'(m.high) * PCT_SCALE) / period);
                    m.freq = FREQ_W'(32'(tick_rate) / period);
                end else begin
                    m.zero = 1'b1;
                end
                phase = PH_IDLE;
                done  = 1'b1;
            end
            prev_level = it.pin;
            tick_count = now + 1'b1;
        end
        return done;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pin_item it;
        t_meas     m;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                it.kind = t_item_kind'(i_s_axis_tuser[0]);
                it.pin  = i_s_axis_tdata[0];
                if (capture_step(it, m))
                    meas_expect_q.push_back(m);
                taken_cnt++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (meas_expect_q.size() == 0) begin
                    $error("result with none expected: tdata %h", o_m_axis_tdata);
                    err_cnt++;
                end else begin
                    m = meas_expect_q.pop_front();
                    check_field("high_ticks",   32'(m.high), 32'(o_m_axis_tdata[15:0]));
                    check_field("low_ticks",    32'(m.low),  32'(o_m_axis_tdata[31:16]));
                    check_field("duty_percent", 32'(m.duty), 32'(o_m_axis_tdata[38:32]));
                    check_field("frequency_hz", 32'(m.freq), 32'(o_m_axis_tdata[62:39]));
                    check_field("tdata_pad",    32'd0,       32'(o_m_axis_tdata[63]));
                    check_field("period_zero",  32'(m.zero), 32'(o_m_axis_tuser[0]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input side: hold the transaction until taken, then maybe idle
    always @(negedge i_clk) begin : driver
        t_pin_item it;
        if (taken_cnt == sent_cnt) begin
            if (pin_stream_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                it = pin_stream_q.pop_front();
                sent_cnt++;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {7'b0, it.pin};
                i_s_axis_tuser  <= it.kind;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_toggle) begin
            hold_seen       <= hold_toggle;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TICK_RATE)
            tick_rate = data[RATE_W-1:0];
    endtask

    task automatic rate_readback();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_TICK_RATE;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("tick_rate_hz", {{(32-RATE_W){1'b0}}, tick_rate}, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_item(input t_item_kind k, input logic pin);
        pin_stream_q.push_back(t_pin_item'{k, pin});
        stim_cnt++;
    endtask

    task automatic push_run(input logic lvl, input int n);
        repeat (n) push_item(KIND_TICK, lvl);
    endtask

    task automatic wait_drained();
        while (pin_stream_q.size() != 0 || taken_cnt != sent_cnt || meas_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain, finish any open capture with edge-forcing ticks, let the divider go quiet.
    task automatic settle();
        wait_drained();
        while (phase != PH_IDLE) begin
            push_item(KIND_TICK, !prev_level);
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_rate(input logic [RATE_W-1:0] rate);
        reg_write(REG_TICK_RATE, {8'($urandom), rate});
        reg_write(REG_SPARE, $urandom);
        rate_readback();
    endtask

    task automatic random_traffic(input int n);
        int   stop_at;
        int   runs;
        int   len;
        logic lvl;
        stop_at = stim_cnt + n;
        while (stim_cnt < stop_at) begin
            if ($urandom_range(99) < 10) begin
                // noise: loose ticks and stray starts
                repeat ($urandom_range(1, 6))
                    push_item(t_item_kind'($urandom_range(3) == 0), 1'($urandom_range(1)));
            end else begin
                push_item(KIND_START, 1'($urandom_range(1)));
                lvl  = 1'($urandom_range(1));
                runs = $urandom_range(3, 6);
                repeat (runs) begin
                    len = ($urandom_range(39) == 0) ? $urandom_range(16, 200)
                                                    : $urandom_range(1, 6);
                    push_run(lvl, len);
                    lvl = !lvl;
                    if ($urandom_range(24) == 0)
                        push_item(KIND_START, 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rate_readback();

        // ticks while idle: no capture
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b0);
        // low tick before the first rise is no edge; shortest period
        push_item(KIND_START, 1'b1);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        // restart in the middle of a capture
        push_item(KIND_START, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_START, 1'b1);
        push_item(KIND_TICK, 1'b0);
        push_run(1'b1, 3);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        settle();

        set_rate(24'd1);
        random_traffic(450);
        settle();

        set_rate(24'd16_000_000);
        no_idle = 1'b1;
        random_traffic(450);
        no_idle = 1'b0;
        settle();

        // long receiver hold-off while the sender keeps going
        set_rate(24'd0);
        hold_toggle = ~hold_toggle;
        random_traffic(400);
        settle();

        // rate beyond the usual range
        set_rate(24'hFF_FFFF);
        random_traffic(300);
        settle();

        set_rate(24'($urandom_range(1, 16_000_000)));
        random_traffic(200);
        settle();
        set_rate(RESET_TICK_RATE);
        random_traffic(80);
        settle();

        if (err_cnt == 0 && meas_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pcm_pkg.sv
rtl/core/pcm_ctrl.sv
rtl/core/pcm_datapath.sv
rtl/core/pwm_capture_measure_top.sv
verif/tb.sv
